// ===== src/ccd_pkg.sv =====
// Shared types and constants for the crossbar differential decoder.
`timescale 1ns / 1ps
package ccd_pkg;

    localparam int MAX_OUTPUTS = 32;
    localparam int MAX_NEURONS = 256;
    localparam int NUM_COLUMNS = 2 * MAX_OUTPUTS;

    localparam int COL_W  = 6;
    localparam int OHMS_W = 24;
    localparam int OIDX_W = 5;
    localparam int VOLT_W = 16;
    localparam int SUM_W  = 48;
    localparam int ALPHA_W = 40;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_CFG = 2'd1;
    localparam logic [1:0] STAT_ZERO_R  = 2'd2;
    localparam logic [1:0] STAT_SAT     = 2'd3;

    localparam logic [1:0] CFG_LOAD_OHMS = 2'd0;
    localparam logic [1:0] CFG_ALPHA     = 2'd1;
    localparam logic [1:0] CFG_AMPLITUDE = 2'd2;

    typedef enum logic [2:0] {
        CK_NOP,
        CK_LOAD,
        CK_ZERO_R,
        CK_CLEAR,
        CK_SAMPLE,
        CK_BAD_CFG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [COL_W-1:0]           col;
        logic [OHMS_W-1:0]          ohms;
        logic [OIDX_W-1:0]          oidx;
        logic signed [VOLT_W-1:0]   vp;
        logic signed [VOLT_W-1:0]   vn;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_DIV,
        ST_LD_WR,
        ST_RDN,
        ST_MULN,
        ST_T1,
        ST_RL0,
        ST_RL1,
        ST_FIN,
        ST_CHK,
        ST_DIV,
        ST_QFIN,
        ST_DONE
    } back_state_t;

endpackage

// ===== src/crossbar_differential_decoder_unit.sv =====
// Top level of the crossbar differential decoder: ports, configuration registers, wiring.
`timescale 1ns / 1ps
// Usage:
//   s_ channel carries requests: tuser = req_type (0 load cell, 1 sample,
//   2 clear sums). m_ channel returns exactly one result per request:
//   tdata = decoded value (Q16.16) and result index, tuser = status.
//   The cfg port writes load_ohms (0), alpha_scale (1) and the spike
//   amplitude (2); write only while no request is in flight.
// Timing:
//   A load request runs a 41-step restoring divide for 2^40/R. A sample
//   request runs the multiply chain, an overflow check and, unless that
//   saturates, a 32-step divide on the same unit. Clear and status-only
//   requests go from idle straight to the done state. The back end's
//   sequencer and its bit-per-cycle divider set the throughput: one
//   request at a time in the back, while a two-entry queue keeps taking
//   requests in the front.
// Reset: (aresetn low, synchronous) empties the queue, drops the result,
//   marks all 64 column sums as zero and restores configuration defaults.
// Stall: a result waits in the output register while m_tready is low; the
//   back end holds its next result, and the queue fills then deasserts
//   s_tready.
module crossbar_differential_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] column_index, [29:6] cell_ohms, [34:30] output select,
    // [50:35] positive column voltage, [66:51] negative column voltage, rest zero
    input  logic [71:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] decoded_value, [36:32] result_index, rest zero
    output logic [39:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_wdata
);
    import ccd_pkg::*;

    logic [OHMS_W-1:0]  load_ohms_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [VOLT_W-1:0]  amp_reg;

    cmd_t front_cmd;
    cmd_t q_head;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic s_accept;

    // hold configuration; defaults out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ohms_reg <= 24'd1000;
            alpha_reg     <= 40'd1;
            amp_reg       <= 16'd4096;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOAD_OHMS: load_ohms_reg <= cfg_wdata[23:0];
                CFG_ALPHA:     alpha_reg     <= cfg_wdata[39:0];
                CFG_AMPLITUDE: amp_reg       <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // accept a request whenever the queue has room
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    ccd_front u_front (
        .req_type         (s_tuser),
        .column_index     (s_tdata[5:0]),
        .cell_ohms        (s_tdata[29:6]),
        .out_sel          (s_tdata[34:30]),
        .vpos             (s_tdata[50:35]),
        .vneg             (s_tdata[66:51]),
        .load_ohms        (load_ohms_reg),
        .alpha_scale      (alpha_reg),
        .amp_q12          (amp_reg),
        .cmd              (front_cmd)
    );

    ccd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_accept),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    ccd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .load_ohms       (load_ohms_reg),
        .alpha_scale     (alpha_reg),
        .amp_q12         (amp_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== src/ccd_front.sv =====
// Front end: classifies an incoming request into a command for the back end.
`timescale 1ns / 1ps
module ccd_front (
    input  logic [1:0]                   req_type,
    input  logic [ccd_pkg::COL_W-1:0]    column_index,
    input  logic [ccd_pkg::OHMS_W-1:0]   cell_ohms,
    input  logic [ccd_pkg::OIDX_W-1:0]   out_sel,
    input  logic [ccd_pkg::VOLT_W-1:0]   vpos,
    input  logic [ccd_pkg::VOLT_W-1:0]   vneg,
    input  logic [ccd_pkg::OHMS_W-1:0]   load_ohms,
    input  logic [ccd_pkg::ALPHA_W-1:0]  alpha_scale,
    input  logic [ccd_pkg::VOLT_W-1:0]   amp_q12,
    output ccd_pkg::cmd_t                cmd
);
    import ccd_pkg::*;

    logic cfg_bad;
    logic out_bad;
    logic col_bad;

    assign cfg_bad = (load_ohms == '0) || (alpha_scale == '0) || (amp_q12 == '0);
    assign out_bad = (6'(out_sel) >= 6'(MAX_OUTPUTS));
    assign col_bad = (7'(column_index) >= 7'(NUM_COLUMNS));

    always_comb begin
        cmd.col  = column_index;
        cmd.ohms = cell_ohms;
        cmd.oidx = out_sel;
        cmd.vp   = vpos;
        cmd.vn   = vneg;
        unique case (req_type)
            REQ_LOAD: begin
                if (cell_ohms == '0)
                    cmd.kind = CK_ZERO_R;
                else if (col_bad)
                    cmd.kind = CK_NOP;
                else
                    cmd.kind = CK_LOAD;
            end
            REQ_SAMPLE: begin
                cmd.kind = (cfg_bad || out_bad) ? CK_BAD_CFG : CK_SAMPLE;
            end
            REQ_CLEAR: cmd.kind = CK_CLEAR;
            default:   cmd.kind = CK_NOP;
        endcase
    end

endmodule

// ===== src/ccd_fifo.sv =====
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module ccd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ccd_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ccd_pkg::cmd_t  head
);
    import ccd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/ccd_back.sv =====
// Back end: conductance sums, decode arithmetic, shared divider and result register.
`timescale 1ns / 1ps
module ccd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  ccd_pkg::cmd_t                q_head,
    output logic                         q_pop,
    input  logic [ccd_pkg::OHMS_W-1:0]   load_ohms,
    input  logic [ccd_pkg::ALPHA_W-1:0]  alpha_scale,
    input  logic [ccd_pkg::VOLT_W-1:0]   amp_q12,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,
    output logic [1:0]                   m_tuser
);
    import ccd_pkg::*;

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]        mem [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0]  vld_reg;
    logic [SUM_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic                    rd_en;
    logic [COL_W-1:0]        rd_addr;
    logic [SUM_W-1:0]        g_val;

    cmd_t                    cmd_reg;
    logic signed [64:0]      pp_reg, pn_reg;
    logic signed [65:0]      t1_reg;
    logic signed [127:0]     acc_reg;
    logic [127:0]            mag_reg;
    logic                    neg_reg;
    logic [63:0]             ar_reg;
    logic [79:0]             den_reg;
    logic [79:0]             div_rem_reg;
    logic [127:0]            div_num_reg;
    logic [40:0]             div_q_reg;
    logic [6:0]              div_cnt_reg;

    logic [31:0]             res_val_reg;
    logic [OIDX_W-1:0]       res_idx_reg;
    logic [1:0]              res_st_reg;
    logic                    m_tvalid_reg;
    logic [39:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;
    logic                    out_free;

    logic [80:0]             trial;
    logic                    trial_ge;
    logic [79:0]             rem_step;
    logic [48:0]             ld_sum;
    logic signed [16:0]      vdiff;
    logic signed [127:0]     t_full;
    logic [15:0]             amp_mag;
    logic [31:0]             q32;
    logic [31:0]             lim;

    assign g_val    = rd_vld_reg ? rd_data_reg : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    assign trial    = {div_rem_reg, div_num_reg[127]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign rem_step = trial_ge ? 80'(trial - {1'b0, den_reg}) : trial[79:0];

    assign ld_sum   = {1'b0, g_val} + {8'b0, div_q_reg};
    assign vdiff    = 17'(cmd_reg.vp) - 17'(cmd_reg.vn);
    assign t_full   = (acc_reg + (128'(vdiff) <<< 40)) <<< 16;
    assign amp_mag  = amp_q12[15] ? 16'(-amp_q12) : amp_q12;
    assign q32      = div_q_reg[31:0];
    assign lim      = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_head.kind)
                        CK_LOAD:   state_next = ST_LD_DIV;
                        CK_SAMPLE: state_next = ST_RDN;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LD_DIV: if (div_cnt_reg == 7'd1) state_next = ST_LD_WR;
            ST_LD_WR:  state_next = ST_DONE;
            ST_RDN:    state_next = ST_MULN;
            ST_MULN:   state_next = ST_T1;
            ST_T1:     state_next = ST_RL0;
            ST_RL0:    state_next = ST_RL1;
            ST_RL1:    state_next = ST_FIN;
            ST_FIN:    state_next = ST_CHK;
            ST_CHK: begin
                if (mag_reg >= {16'b0, den_reg, 32'b0})
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:    if (div_cnt_reg == 7'd1) state_next = ST_QFIN;
            ST_QFIN:   state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop   = (state_reg == ST_IDLE) && !q_empty;
        rd_en   = (state_reg == ST_IDLE) || (state_reg == ST_RDN);
        rd_addr = q_head.col;
        if (state_reg == ST_RDN)
            rd_addr = {cmd_reg.oidx, 1'b1};
        else if (q_head.kind == CK_SAMPLE)
            rd_addr = {q_head.oidx, 1'b0};
    end

    // sum memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LD_WR)
            mem[cmd_reg.col] <= ld_sum[48] ? {SUM_W{1'b1}} : ld_sum[47:0];
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
            if (q_pop && q_head.kind == CK_CLEAR)
                vld_reg <= '0;
            else if (state_reg == ST_LD_WR)
                vld_reg[cmd_reg.col] <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg     <= q_head;
                res_val_reg <= '0;
                res_idx_reg <= '0;
                res_st_reg  <= STAT_OK;
                div_rem_reg <= '0;
                div_num_reg <= {1'b1, 127'b0};
                div_q_reg   <= '0;
                div_cnt_reg <= 7'd41;
                den_reg     <= {56'b0, q_head.ohms};
                if (q_head.kind == CK_ZERO_R)
                    res_st_reg <= STAT_ZERO_R;
                if (q_head.kind == CK_BAD_CFG) begin
                    res_st_reg  <= STAT_BAD_CFG;
                    res_idx_reg <= q_head.oidx;
                end
                if (q_head.kind == CK_SAMPLE)
                    res_idx_reg <= q_head.oidx;
            end
            ST_LD_DIV, ST_DIV: begin
                div_rem_reg <= rem_step;
                div_num_reg <= {div_num_reg[126:0], 1'b0};
                div_q_reg   <= {div_q_reg[39:0], trial_ge};
                div_cnt_reg <= div_cnt_reg - 7'd1;
            end
            ST_LD_WR: begin
                if (ld_sum[48])
                    res_st_reg <= STAT_SAT;
            end
            ST_RDN: begin
                pp_reg <= 65'(cmd_reg.vp) * 65'($signed({1'b0, g_val}));
                ar_reg <= 64'(alpha_scale) * 64'(load_ohms);
            end
            ST_MULN: begin
                pn_reg  <= 65'(cmd_reg.vn) * 65'($signed({1'b0, g_val}));
                den_reg <= 80'(ar_reg) * 80'(amp_mag);
            end
            ST_T1:  t1_reg <= 66'(pp_reg) - 66'(pn_reg);
            ST_RL0: acc_reg <= 128'(t1_reg) * 128'($signed({1'b0, load_ohms[11:0]}));
            ST_RL1: acc_reg <= acc_reg
                             + ((128'(t1_reg) * 128'($signed({1'b0, load_ohms[23:12]})))
                                <<< 12);
            ST_FIN: begin
                mag_reg <= t_full[127] ? 128'(-t_full) : 128'(t_full);
                neg_reg <= t_full[127] ^ amp_q12[15];
            end
            ST_CHK: begin
                div_rem_reg <= mag_reg[111:32];
                div_num_reg <= {mag_reg[31:0], 96'b0};
                div_q_reg   <= '0;
                div_cnt_reg <= 7'd32;
                if (mag_reg >= {16'b0, den_reg, 32'b0}) begin
                    res_st_reg  <= STAT_SAT;
                    res_val_reg <= neg_reg ? 32'(-lim) : lim;
                end
            end
            ST_QFIN: begin
                if (q32 > lim) begin
                    res_st_reg  <= STAT_SAT;
                    res_val_reg <= neg_reg ? 32'(-lim) : lim;
                end else begin
                    res_val_reg <= neg_reg ? 32'(-q32) : q32;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {3'b0, res_idx_reg, res_val_reg};
            m_tuser_reg <= res_st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
